// ===== rtl/fwom_pkg.sv =====
package fwom_pkg;

  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned DataW     = 32;
  localparam int unsigned LfsrW     = 23;
  localparam int unsigned QuoW      = 23;
  localparam int unsigned DivisorW  = 11;
  localparam int unsigned CntW      = 5;

  localparam logic [QuoW-1:0]     Dividend   = 23'd8386560;
  localparam logic [CntW-1:0]     DivLast    = 5'd22;
  localparam logic [15:0]         LevelCap   = 16'd65520;
  localparam logic [LfsrW-1:0]    LfsrSeed   = 23'h7FFFFF;
  localparam logic [11:0]         PwReset    = 12'h800;
  localparam logic [DataW-1:0]    FullLevel  = 32'h0FFF_0000;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_WAVEFORM    = 3'd0,
    CFG_PHASE_STEP  = 3'd1,
    CFG_PHASE_OFFS  = 3'd2,
    CFG_PULSE_WIDTH = 3'd3,
    CFG_MIX_ENABLE  = 3'd4,
    CFG_AMP_STEP    = 3'd5
  } cfg_addr_e;

  typedef enum logic [1:0] {
    WAVE_TRIANGLE = 2'd0,
    WAVE_SAW      = 2'd1,
    WAVE_PULSE    = 2'd2,
    WAVE_NOISE    = 2'd3
  } wave_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic lvl_load;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/four_wave_oscillator_mixer_unit.sv =====
// a beat is registered on input, then ST_MUL forms the product and ST_FIN loads the output
// register once it is free; a pulse beat that needs the level divide first passes ST_DIV (a
// bit-serial divider for 23 quotient bits) and ST_LVL (the level load) before ST_MUL
// a new beat is taken only once the previous result is in the output register, also while it waits there
// reset: asynchronous active-low rst_ni clears phase, amplitude and config,
// loads the noise register with all ones and the pulse width with 2048
module four_wave_oscillator_mixer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fwom_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [fwom_pkg::DataW-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // start_amplitude, existing_sample
  input  logic                          s_axis_tuser,  // block_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fwom_pkg::DataW-1:0]    m_axis_tdata   // sample
);
  import fwom_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fwom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fwom_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .block_start_i (s_axis_tuser),
    .start_amp_i   (s_axis_tdata[31:0]),
    .exist_i       (s_axis_tdata[63:32]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_data_o    (m_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ===== rtl/fwom_ctrl.sv =====
module fwom_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fwom_pkg::sts_t sts_i,
  output fwom_pkg::cmd_t cmd_o
);
  import fwom_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LVL,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   load;

  assign load       = in_valid_i && ready_q;
  assign in_ready_o = ready_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = load;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.lvl_load = (state_q == ST_LVL);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.out_load = (state_q == ST_FIN) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (load) begin
            ready_q <= 1'b0;
            state_q <= sts_i.need_div ? ST_DIV : ST_MUL;
          end
        end
        ST_DIV: begin
          if (sts_i.div_last) begin
            state_q <= ST_LVL;
          end
        end
        ST_LVL: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/fwom_dp.sv =====
module fwom_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fwom_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [fwom_pkg::DataW-1:0]      cfg_wdata_i,
  input  logic                            block_start_i,
  input  logic [fwom_pkg::DataW-1:0]      start_amp_i,
  input  logic [fwom_pkg::DataW-1:0]      exist_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [fwom_pkg::DataW-1:0]      out_data_o,
  input  fwom_pkg::cmd_t                  cmd_i,
  output fwom_pkg::sts_t                  sts_o
);
  import fwom_pkg::*;

  // configuration
  logic [1:0]       wave_q;
  logic [DataW-1:0] step_q;
  logic [DataW-1:0] offs_q;
  logic [11:0]      pw_q;
  logic             mix_q;
  logic [DataW-1:0] astep_q;

  // oscillator state
  logic [DataW-1:0] phase_q;
  logic [LfsrW-1:0] lfsr_q;
  logic [DataW-1:0] amp_q;

  // per-beat work registers
  logic [DataW-1:0]    exist_q;
  logic [DataW-1:0]    raw_q;
  logic [DataW-1:0]    prod_q;
  logic [DivisorW-1:0] rem_q;
  logic [QuoW-1:0]     quo_q;
  logic [CntW-1:0]     cnt_q;
  logic [DivisorW-1:0] dvs_q;
  logic                out_valid_q;
  logic [DataW-1:0]    out_data_q;

  logic [DataW-1:0]    phase_next;
  logic [DataW-1:0]    offs_phase;
  logic [11:0]         idx;
  logic [11:0]         tri_val;
  logic                lfsr_clk;
  logic [LfsrW-1:0]    lfsr_new;
  logic [11:0]         taps;
  logic [32:0]         m_sum;
  logic [12:0]         m_raw;
  logic [12:0]         m_val;
  logic [12:0]         pw_ext;
  logic [12:0]         pw_a;
  logic [12:0]         pw_b;
  logic [12:0]         pw_dist;
  logic                silent;
  logic                high;
  logic                need_div;
  logic [DataW-1:0]    raw_sel;
  logic [11:0]         trial;
  logic                ge;
  logic [11:0]         diff;
  logic signed [63:0]  prod;
  logic                sat;

  assign phase_next = phase_q + step_q;
  assign offs_phase = phase_q + offs_q;
  assign idx        = offs_phase[31:20];
  assign tri_val    = {idx[10:0] ^ {11{idx[11]}}, 1'b0};

  assign lfsr_clk = !phase_q[19] && phase_next[19];
  assign lfsr_new = lfsr_clk ? {lfsr_q[21:0], lfsr_q[22] ^ lfsr_q[17]} : lfsr_q;
  assign taps = {lfsr_new[20], lfsr_new[18], lfsr_new[14], lfsr_new[11],
                 lfsr_new[9], lfsr_new[5], lfsr_new[2], lfsr_new[0], 4'b0000};

  // pulse width clamp against the phase step
  assign m_sum  = {1'b0, step_q} + 33'h0_0008_0000;
  assign m_raw  = m_sum[32:20];
  assign m_val  = (m_raw == 13'd0) ? 13'd1 : m_raw;
  assign pw_ext = {1'b0, pw_q};
  assign pw_a   = (pw_ext < m_val) ? m_val : pw_ext;

  always_comb begin
    pw_b = pw_a;
    if ((pw_a <= 13'd4095) && ((13'd4095 - pw_a) < m_val)) begin
      pw_b = 13'd4095 - m_val;
    end
  end

  assign pw_dist  = (pw_b <= 13'd2048) ? pw_b : (13'd4095 - pw_b);
  assign silent   = (pw_q == 12'd0) || (pw_q == 12'hFFF);
  assign high     = ({1'b0, phase_q[31:20]} < pw_b);
  assign need_div = (wave_q == WAVE_PULSE) && !silent && high && (pw_b != 13'd0)
                    && (pw_b < 13'd4095) && (pw_dist < 13'd2048);

  always_comb begin
    case (wave_e'(wave_q))
      WAVE_TRIANGLE: raw_sel = {1'b0, tri_val, 19'd0};
      WAVE_SAW:      raw_sel = {1'b0, idx, 19'd0};
      WAVE_NOISE:    raw_sel = {1'b0, taps, 19'd0};
      WAVE_PULSE: begin
        if (silent || !high || need_div) begin
          raw_sel = '0;
        end else begin
          raw_sel = FullLevel;
        end
      end
      default:       raw_sel = '0;
    endcase
  end

  // restoring divider, one quotient bit a cycle
  assign trial = {rem_q, quo_q[QuoW-1]};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  assign prod = $signed(raw_q) * $signed(amp_q);
  assign sat  = (raw_q == 32'h8000_0000) && (amp_q == 32'h8000_0000);

  assign sts_o.need_div = need_div;
  assign sts_o.div_last = (cnt_q == DivLast);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q  <= WAVE_TRIANGLE;
      step_q  <= '0;
      offs_q  <= '0;
      pw_q    <= PwReset;
      mix_q   <= 1'b0;
      astep_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_WAVEFORM:    wave_q  <= cfg_wdata_i[1:0];
        CFG_PHASE_STEP:  step_q  <= cfg_wdata_i;
        CFG_PHASE_OFFS:  offs_q  <= cfg_wdata_i;
        CFG_PULSE_WIDTH: pw_q    <= cfg_wdata_i[11:0];
        CFG_MIX_ENABLE:  mix_q   <= cfg_wdata_i[0];
        CFG_AMP_STEP:    astep_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      lfsr_q      <= LfsrSeed;
      amp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        phase_q <= phase_next;
        if (wave_q == WAVE_NOISE) begin
          lfsr_q <= lfsr_new;
        end
        if (block_start_i) begin
          amp_q <= start_amp_i;
        end
      end
      if (cmd_i.mul && mix_q) begin
        amp_q <= amp_q + astep_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      exist_q <= exist_i;
      raw_q   <= raw_sel;
      dvs_q   <= pw_dist[DivisorW-1:0];
      quo_q   <= Dividend;
      rem_q   <= '0;
      cnt_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_q <= {quo_q[QuoW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.lvl_load) begin
      raw_q <= {(quo_q > {7'd0, LevelCap}) ? LevelCap : quo_q[15:0], 16'd0};
    end
    if (cmd_i.mul) begin
      prod_q <= sat ? 32'h7FFF_FFFF : prod[62:31];
    end
    if (cmd_i.out_load) begin
      out_data_q <= mix_q ? (prod_q + exist_q) : raw_q;
    end
  end

endmodule
